@@ hw/rtl/lprd_pkg.sv @@
package lprd_pkg;

	localparam logic [1:0] PH_LENGTH  = 2'd0;
	localparam logic [1:0] PH_TAG     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	typedef struct packed {
		logic       valid;
		logic [7:0] record_tag;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       last_of_record;
		logic       empty_record;
	} result_t;

endpackage

@@ hw/rtl/lprd_parser.sv @@
module lprd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              opcode,
	input  logic [7:0]        stream_byte,
	output lprd_pkg::result_t result
);
	import lprd_pkg::*;

	logic [1:0] phase_q;
	logic [7:0] length_q;
	logic [7:0] tag_q;
	logic [7:0] seen_q;

	logic [1:0] phase_d;
	logic [7:0] length_d;
	logic [7:0] tag_d;
	logic [7:0] seen_d;
	logic [8:0] next_count;
	logic       is_last;

	assign next_count = {1'b0, seen_q} + 9'd1;
	assign is_last    = next_count >= {1'b0, length_q};

	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		tag_d    = tag_q;
		seen_d   = seen_q;
		result   = '0;
		if (opcode == OP_CLOSE) begin
			phase_d  = PH_LENGTH;
			length_d = '0;
			seen_d   = '0;
		end else begin
			unique case (phase_q)
				PH_TAG: begin
					tag_d  = stream_byte;
					seen_d = '0;
					if (length_q == 8'd0) begin
						result.valid          = 1'b1;
						result.record_tag     = stream_byte;
						result.last_of_record = 1'b1;
						result.empty_record   = 1'b1;
						phase_d               = PH_LENGTH;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					result.valid          = 1'b1;
					result.record_tag     = tag_q;
					result.payload_byte   = stream_byte;
					result.byte_index     = seen_q;
					result.last_of_record = is_last;
					seen_d                = next_count[7:0];
					if (is_last) begin
						phase_d = PH_LENGTH;
						seen_d  = '0;
					end
				end
				default: begin
					length_d = stream_byte;
					seen_d   = '0;
					phase_d  = PH_TAG;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			length_q <= '0;
			tag_q    <= '0;
			seen_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			tag_q    <= tag_d;
			seen_q   <= seen_d;
		end
	end

endmodule

@@ hw/rtl/length_prefixed_record_deframer_top.sv @@
// channel  | direction | handshake                    | contents
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: stream_byte; tuser: opcode
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata/tuser/tlast: one payload word
// cfg      | in        | cfg_valid/cfg_ready          | cfg_data: deliver_enable
//
// One word per clock sustained while the output is not stalled.
// The input register and the result register set the rate; parsing sits between them.
// arst_n clears the parser to expecting a length byte and disables delivery.
// A stalled output holds the input register; the input side keeps flowing while
// the result register drains in the same cycle.
module length_prefixed_record_deframer_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	input  logic        s_axis_tuser,   // [0] opcode

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index
	output logic [8:0]  m_axis_tuser,   // [7:0] record_tag, [8] empty_record
	output logic        m_axis_tlast,   // last_of_record

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data        // deliver_enable
);
	import lprd_pkg::*;

	logic       deliver_en_q;
	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       m_valid_q;
	result_t    result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			deliver_en_q <= cfg_data;
		end
	end

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= s_axis_tuser;
			byte_s1   <= s_axis_tdata;
		end
	end

	lprd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.opcode      (opcode_s1),
		.stream_byte (byte_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= result.valid && deliver_en_q;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= {result.byte_index, result.payload_byte};
			m_axis_tuser <= {result.empty_record, result.record_tag};
			m_axis_tlast <= result.last_of_record;
		end
	end

	assign m_axis_tvalid = m_valid_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[8] |-> m_axis_tlast && m_axis_tdata == 16'd0)
		else $error("empty record word without last mark or with data");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q && !deliver_en_q |=> !m_valid_q)
		else $error("word produced while delivery disabled");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_valid_q && !m_axis_tready)
		else $error("input stalled without a blocked output");

endmodule
